// ===== sv/bht_pkg.sv =====
// Shared types, field widths and codes for the bucketed hash table.
package bht_pkg;

    localparam int KEY_W      = 31;
    localparam int VAL_W      = 64;
    localparam int ACT_W      = 2;
    localparam int STAT_W     = 2;
    localparam int S_TDATA_W  = 96;  // key + value, padded to whole bytes
    localparam int M_TDATA_W  = 64;  // value_out
    localparam int S_TUSER_W  = ACT_W;
    localparam int M_TUSER_W  = 1 + STAT_W;

    typedef logic [ACT_W-1:0]  t_action;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_action ACT_INSERT = 2'd0;
    localparam t_action ACT_DELETE = 2'd1;
    localparam t_action ACT_LOOKUP = 2'd2;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_REFUSED = 2'd1;
    localparam t_status ST_FULL    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load_in;   // capture the input transaction
        logic clr_step;  // write one cleared row during the init sweep
        logic rd;        // read the bucket row
        logic commit;    // update the row and load the result register
    } t_bht_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;  // sweep is at the last row
        logic out_free;  // result register can take a new result
    } t_bht_sts;

endpackage

// ===== sv/bht_ctrl.sv =====
// Sequencer for the bucketed hash table: init sweep, hash, read, commit.
module bht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bht_pkg::t_bht_sts i_sts,
    output bht_pkg::t_bht_cmd o_cmd
);
    import bht_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_HASH3,
        S_READ,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_HASH1;
                end
            end
            S_HASH1: n_state = S_HASH2;   // key * reciprocal
            S_HASH2: n_state = S_HASH3;   // quotient * bucket count
            S_HASH3: n_state = S_READ;    // remainder correction
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/bht_datapath.sv =====
// Datapath: bucket hash, row memory, slot compare, row update, result register.
module bht_datapath #(
    parameter int BUCKETS          = 100,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bht_pkg::t_bht_cmd              i_cmd,
    output bht_pkg::t_bht_sts              o_sts,
    input  logic [bht_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic [bht_pkg::S_TUSER_W-1:0]  i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [bht_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic [bht_pkg::M_TUSER_W-1:0]  o_m_tuser
);
    import bht_pkg::*;

    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int BKT_W = $clog2(BUCKETS + 1);
    localparam int REM_W = BKT_W + 1;
    localparam int NS    = SLOTS_PER_BUCKET;
    // floor(2^31 / BUCKETS): quotient estimate is exact or one low
    localparam logic [31:0]      RECIP  = 32'((64'd1 << KEY_W) / BUCKETS);
    localparam logic [BKT_W-1:0] BCONST = BKT_W'(BUCKETS);
    localparam logic [REM_W-1:0] BREM   = REM_W'(BUCKETS);

    // captured transaction
    t_action          r_action;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;

    // bucket = key mod BUCKETS, three stages
    logic [KEY_W+31:0] r_prod;
    logic [KEY_W-1:0]  r_qb;
    logic [BW-1:0]     r_bucket;
    logic [KEY_W-1:0]  diff;
    logic [REM_W-1:0]  rem;

    // row memory
    logic [NS-1:0]             mem_mask [BUCKETS];
    logic [NS-1:0][KEY_W-1:0]  mem_key  [BUCKETS];
    logic [NS-1:0][VAL_W-1:0]  mem_val  [BUCKETS];
    logic [NS-1:0]             r_mask;
    logic [NS-1:0][KEY_W-1:0]  r_keys;
    logic [NS-1:0][VAL_W-1:0]  r_vals;
    logic [BW-1:0]             r_clr_addr;

    // compare / update
    logic [NS-1:0]            hit_vec;
    logic [NS-1:0]            free_vec;
    logic [NS-1:0]            free_oh;
    logic                     any_hit;
    logic                     any_free;
    logic [VAL_W-1:0]         hit_val;
    logic [NS-1:0]            n_mask;
    logic [NS-1:0][KEY_W-1:0] n_keys;
    logic [NS-1:0][VAL_W-1:0] n_vals;
    logic                     mask_we;
    logic                     data_we;
    logic                     res_found;
    logic [VAL_W-1:0]         res_val;
    t_status                  res_status;

    // result register
    logic             r_out_valid;
    logic             r_out_found;
    logic [VAL_W-1:0] r_out_val;
    t_status          r_out_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_s_tuser;
            r_key    <= i_s_tdata[KEY_W-1:0];
            r_value  <= i_s_tdata[KEY_W+VAL_W-1:KEY_W];
        end
    end

    assign diff = r_key - r_qb;

    always_comb begin
        rem = diff[REM_W-1:0];
        if (rem >= BREM) rem = rem - BREM;
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= r_key * RECIP;
        r_qb     <= KEY_W'(r_prod[2*KEY_W-1:KEY_W] * BCONST);
        r_bucket <= BW'(rem);
    end

    // init sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + BW'(1);
        end
    end

    assign o_sts.clr_last = (r_clr_addr == BW'(BUCKETS - 1));
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    always_comb begin
        hit_vec  = '0;
        free_vec = '0;
        hit_val  = '0;
        for (int s = 0; s < NS; s++) begin
            hit_vec[s]  = r_mask[s] && (r_keys[s] == r_key);
            free_vec[s] = !r_mask[s];
            if (hit_vec[s]) hit_val = hit_val | r_vals[s];
        end
        free_oh  = free_vec & (~free_vec + NS'(1));
        any_hit  = |hit_vec;
        any_free = |free_vec;
        n_keys   = r_keys;
        n_vals   = r_vals;
        for (int s = 0; s < NS; s++) begin
            if (free_oh[s]) begin
                n_keys[s] = r_key;
                n_vals[s] = r_value;
            end
        end

        n_mask     = r_mask;
        mask_we    = 1'b0;
        data_we    = 1'b0;
        res_found  = 1'b0;
        res_val    = '0;
        res_status = ST_REFUSED;
        case (r_action)
            ACT_INSERT: begin
                if (!any_hit) begin
                    if (!any_free) begin
                        res_status = ST_FULL;
                    end else begin
                        n_mask     = r_mask | free_oh;
                        mask_we    = 1'b1;
                        data_we    = 1'b1;
                        res_found  = 1'b1;
                        res_status = ST_OK;
                    end
                end
            end
            ACT_DELETE: begin
                if (any_hit) begin
                    n_mask     = r_mask & ~hit_vec;
                    mask_we    = 1'b1;
                    res_found  = 1'b1;
                    res_status = ST_OK;
                end
            end
            ACT_LOOKUP: begin
                if (any_hit) begin
                    res_found  = 1'b1;
                    res_val    = hit_val;
                    res_status = ST_OK;
                end
            end
            default: res_status = ST_REFUSED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem_mask[r_clr_addr] <= '0;
        end else if (i_cmd.commit && mask_we) begin
            mem_mask[r_bucket] <= n_mask;
        end
        if (i_cmd.commit && data_we) begin
            mem_key[r_bucket] <= n_keys;
            mem_val[r_bucket] <= n_vals;
        end
        if (i_cmd.rd) begin
            r_mask <= mem_mask[r_bucket];
            r_keys <= mem_key[r_bucket];
            r_vals <= mem_val[r_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_found  <= res_found;
            r_out_val    <= res_val;
            r_out_status <= res_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_val;
    assign o_m_tuser  = {r_out_status, r_out_found};

endmodule

// ===== sv/bucketed_hash_table_unit.sv =====
// Top level of the bucketed hash table: stream ports, controller and datapath.
// Result path: key mod BUCKETS pipeline, bucket row read, then compare and
//   row write-back (commit waits while the previous result is still held downstream).
// Transactions are serialized: a new one is accepted only after the previous
//   one has finished its bucket row read-modify-write.
// Reset: synchronous active low; afterwards an init sweep over all BUCKETS rows
//   clears every row's slot-valid mask, with s_axis tready held low meanwhile.
module bucketed_hash_table_unit #(
    parameter int BUCKETS          = 100,
    parameter int SLOTS_PER_BUCKET = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [bht_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // key[30:0], value[94:31], 0
    input  logic [bht_pkg::S_TUSER_W-1:0] i_s_axis_tuser,  // action[1:0]
    // result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [bht_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // value_out[63:0]
    output logic [bht_pkg::M_TUSER_W-1:0] o_m_axis_tuser   // found[0], status[2:1]
);
    import bht_pkg::*;

    t_bht_cmd cmd;
    t_bht_sts sts;

    // Controller walks: init sweep -> idle -> hash x3 -> read -> commit.
    // Commit waits only if the previous result is still held downstream.
    bht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath holds the row memory (valid mask, keys, values per bucket)
    // and the result register that decouples the two stream sides.
    bht_datapath #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== sv/bht_checker.sv =====
// Port-level assertions for the bucketed hash table, bound to the top level.
module bht_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [bht_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input logic [bht_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);
    import bht_pkg::*;

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // found is set exactly when status is ok
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[0] == (o_m_axis_tuser[2:1] == ST_OK)))
        else $error("found and status disagree");

    // a miss or refusal returns zero value
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> (o_m_axis_tdata == '0))
        else $error("nonzero value without hit");

    // one item in flight: ready drops after an accepted transaction
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second item accepted while busy");

endmodule

bind bucketed_hash_table_unit bht_checker u_bht_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
